// ===== sv/bqis_pkg.sv =====
// shared types, codes and the encoder decode table of the input scanner
package bqis_pkg;

  localparam int SCAN_MAX = 8;
  localparam int HOLD_W   = 16;

  // result action codes
  localparam logic [2:0] ACT_CLICK      = 3'd0;
  localparam logic [2:0] ACT_LONG_DOWN  = 3'd1;
  localparam logic [2:0] ACT_LONG_UP    = 3'd2;
  localparam logic [2:0] ACT_TURN_RIGHT = 3'd3;
  localparam logic [2:0] ACT_TURN_LEFT  = 3'd4;

  localparam logic [3:0] SRC_ENCODER = 4'd8;

  // configuration register indexes
  localparam logic [2:0] REG_BTN_DIV = 3'd0;
  localparam logic [2:0] REG_ENC_DIV = 3'd1;
  localparam logic [2:0] REG_REP_DIV = 3'd2;
  localparam logic [2:0] REG_LONG    = 3'd3;
  localparam logic [2:0] REG_LONG_EN = 3'd4;

  typedef struct packed {
    logic [6:0] step_count;
    logic [2:0] action;
    logic [3:0] source;
  } bqis_res_t;

  // per-button word kept in memory
  typedef struct packed {
    logic              prev_level;
    logic [HOLD_W-1:0] hold;
  } bqis_btn_t;

  // half-step decode: history in, signed step out
  function automatic logic signed [1:0] half_step(input logic [3:0] hist);
    logic signed [1:0] d;
    case (hist)
      4'd2, 4'd13: d = -2'sd1;
      4'd7, 4'd8:  d = 2'sd1;
      default:     d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/bqis_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module bqis_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/button_and_quadrature_input_scanner.sv =====
// button and quadrature encoder scanner: top level
//
// in channel: one beat per tick, carrying the active-low button levels and
// the encoder phases. out channel: button events (short click, long down,
// long up) in button order, then at most one encoder report with direction
// and step count; tlast marks the final beat caused by a tick. a tick that
// causes nothing gives no beat.
// cfg: apb-style register port, to be written only while the block is idle;
// the block itself does not enforce this. each accepted beat walks the
// per-button memory, when buttons are sampled, one entry a cycle unless the
// result side stalls (one read port, one write port, registered read data),
// then updates the encoder and the report. in_tready is high only between
// ticks.
// results pass through a pending register and an output register, so a
// stalled receiver holds the scan only when both are full.
// reset: dividers and counters to their defaults, all buttons released,
// encoder history 3, accumulator cleared; per-button valid bits make the
// memory read as released until an entry is written.
module button_and_quadrature_input_scanner
  import bqis_pkg::*;
#(
  parameter int BUTTONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] button_levels, [8] phase_a, [9] phase_b
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // out_tdata: [3:0] source, [6:4] action, [13:7] step_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SCAN  = BUTTONS < SCAN_MAX ? BUTTONS : SCAN_MAX;
  localparam int IDX_W = SCAN > 1 ? $clog2(SCAN) : 1;
  localparam int WORD_W = $bits(bqis_btn_t);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BTN  = 3'd1;
  localparam logic [2:0] ST_ENC  = 3'd2;
  localparam logic [2:0] ST_REP  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // configuration
  logic [15:0] btn_div_r, enc_div_r, rep_div_r, long_r;
  logic [7:0]  long_en_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // control and datapath state
  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SCAN-1:0]   vld_r, vld_nxt;
  logic [7:0]        levels_r, levels_nxt;
  logic              pha_r, pha_nxt, phb_r, phb_nxt;
  logic              enc_fire_r, enc_fire_nxt, rep_fire_r, rep_fire_nxt;
  logic [15:0]       btn_cnt_r, btn_cnt_nxt, enc_cnt_r, enc_cnt_nxt;
  logic [15:0]       rep_cnt_r, rep_cnt_nxt;
  logic [3:0]        hist_r, hist_nxt;
  logic signed [7:0] acc_r, acc_nxt;
  logic              pend_v_r, pend_v_nxt;
  bqis_res_t         pend_r, pend_nxt;
  logic              out_v_r, out_v_nxt, out_last_r, out_last_nxt;
  bqis_res_t         out_r, out_nxt;

  // memory port
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_raddr;
  bqis_btn_t        ram_wdata, ram_rdata;

  // per-button compute
  logic        cur_prev, cur_en, cur_level;
  logic [15:0] cur_hold;
  logic        btn_emit;
  bqis_res_t   btn_res;
  bqis_btn_t   btn_new;

  // encoder
  logic [3:0]        hist_new;
  logic signed [8:0] acc_sum;
  logic signed [7:0] acc_sat, acc_neg;
  logic              rep_emit;
  bqis_res_t         rep_res;

  logic      accept, produce, stall, out_free;
  bqis_res_t prod_res;
  logic      btn_hit, enc_hit, rep_hit;
  logic [15:0] btn_inc, enc_inc, rep_inc;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_div_r <= 16'd1;
      enc_div_r <= 16'd1;
      rep_div_r <= 16'd10;
      long_r    <= 16'd50;
      long_en_r <= 8'hFF;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BTN_DIV: btn_div_r <= cfg_pwdata[15:0];
        REG_ENC_DIV: enc_div_r <= cfg_pwdata[15:0];
        REG_REP_DIV: rep_div_r <= cfg_pwdata[15:0];
        REG_LONG:    long_r    <= cfg_pwdata[15:0];
        REG_LONG_EN: long_en_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BTN_DIV: cfg_prdata = {16'd0, btn_div_r};
      REG_ENC_DIV: cfg_prdata = {16'd0, enc_div_r};
      REG_REP_DIV: cfg_prdata = {16'd0, rep_div_r};
      REG_LONG:    cfg_prdata = {16'd0, long_r};
      REG_LONG_EN: cfg_prdata = {24'd0, long_en_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  bqis_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SCAN)
  ) u_btn_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // divider counters wrap modulo 2^16 and fire on a match
  assign btn_inc = btn_cnt_r + 16'd1;
  assign enc_inc = enc_cnt_r + 16'd1;
  assign rep_inc = rep_cnt_r + 16'd1;
  assign btn_hit = btn_inc == btn_div_r;
  assign enc_hit = enc_inc == enc_div_r;
  assign rep_hit = rep_inc == rep_div_r;

  // entries never written read as released with a zero hold count
  assign cur_prev  = vld_r[idx_r] ? ram_rdata.prev_level : 1'b1;
  assign cur_hold  = vld_r[idx_r] ? ram_rdata.hold : 16'd0;
  assign cur_en    = long_en_r[idx_r];
  assign cur_level = levels_r[idx_r];

  always_comb begin
    btn_emit           = 1'b0;
    btn_res.source     = 4'(idx_r);
    btn_res.action     = ACT_CLICK;
    btn_res.step_count = 7'd1;
    btn_new.prev_level = cur_level;
    btn_new.hold       = cur_hold;
    if (!cur_level) begin
      if (cur_hold == long_r && cur_hold != 16'hFFFF && cur_en) begin
        btn_emit       = 1'b1;
        btn_res.action = ACT_LONG_DOWN;
      end
      if (cur_hold != 16'hFFFF) begin
        btn_new.hold = cur_hold + 16'd1;
      end
    end else if (!cur_prev) begin
      if (cur_hold > long_r) begin
        btn_emit       = cur_en;
        btn_res.action = ACT_LONG_UP;
      end else begin
        btn_emit       = 1'b1;
        btn_res.action = ACT_CLICK;
      end
      btn_new.hold = 16'd0;
    end
  end

  assign hist_new = {hist_r[1:0], pha_r, phb_r};
  assign acc_sum  = 9'(acc_r) + 9'(half_step(hist_new));

  always_comb begin
    if (acc_sum > 9'sd127) begin
      acc_sat = 8'sd127;
    end else if (acc_sum < -9'sd127) begin
      acc_sat = -8'sd127;
    end else begin
      acc_sat = acc_sum[7:0];
    end
  end

  assign acc_neg            = -acc_r;
  assign rep_emit           = rep_fire_r && acc_r != 8'sd0;
  assign rep_res.source     = SRC_ENCODER;
  assign rep_res.action     = acc_r > 8'sd0 ? ACT_TURN_RIGHT : ACT_TURN_LEFT;
  assign rep_res.step_count = acc_r > 8'sd0 ? acc_r[6:0] : acc_neg[6:0];

  assign in_tready = state_r == ST_IDLE;
  assign accept    = in_tvalid & in_tready;
  assign out_free  = !out_v_r || out_tready;
  assign produce   = (state_r == ST_BTN && btn_emit) || (state_r == ST_REP && rep_emit);
  assign prod_res  = state_r == ST_BTN ? btn_res : rep_res;
  // a new result needs the pending slot, which needs the output register
  assign stall     = produce && pend_v_r && !out_free;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    vld_nxt      = vld_r;
    levels_nxt   = levels_r;
    pha_nxt      = pha_r;
    phb_nxt      = phb_r;
    enc_fire_nxt = enc_fire_r;
    rep_fire_nxt = rep_fire_r;
    btn_cnt_nxt  = btn_cnt_r;
    enc_cnt_nxt  = enc_cnt_r;
    rep_cnt_nxt  = rep_cnt_r;
    hist_nxt     = hist_r;
    acc_nxt      = acc_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    ram_wdata    = btn_new;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          levels_nxt   = in_tdata[7:0];
          pha_nxt      = in_tdata[8];
          phb_nxt      = in_tdata[9];
          btn_cnt_nxt  = btn_hit ? 16'd0 : btn_inc;
          enc_cnt_nxt  = enc_hit ? 16'd0 : enc_inc;
          rep_cnt_nxt  = rep_hit ? 16'd0 : rep_inc;
          enc_fire_nxt = enc_hit;
          rep_fire_nxt = rep_hit;
          if (btn_hit) begin
            ram_re    = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_BTN;
          end else begin
            state_nxt = ST_ENC;
          end
        end
      end
      ST_BTN: begin
        if (!stall) begin
          ram_we         = 1'b1;
          vld_nxt[idx_r] = 1'b1;
          if (idx_r == IDX_W'(SCAN - 1)) begin
            state_nxt = ST_ENC;
          end else begin
            // fetch the next entry while this one is written back
            ram_re    = 1'b1;
            ram_raddr = idx_r + 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      ST_ENC: begin
        if (enc_fire_r) begin
          hist_nxt = hist_new;
          acc_nxt  = acc_sat;
        end
        state_nxt = ST_REP;
      end
      ST_REP: begin
        if (!stall) begin
          if (rep_fire_r) begin
            acc_nxt = 8'sd0;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // last is known only once the next result shows up or the tick ends
    if (produce && !stall) begin
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = prod_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      vld_r      <= '0;
      enc_fire_r <= 1'b0;
      rep_fire_r <= 1'b0;
      btn_cnt_r  <= 16'd0;
      enc_cnt_r  <= 16'd0;
      rep_cnt_r  <= 16'd0;
      hist_r     <= 4'd3;
      acc_r      <= 8'sd0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      vld_r      <= vld_nxt;
      enc_fire_r <= enc_fire_nxt;
      rep_fire_r <= rep_fire_nxt;
      btn_cnt_r  <= btn_cnt_nxt;
      enc_cnt_r  <= enc_cnt_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
      hist_r     <= hist_nxt;
      acc_r      <= acc_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    levels_r   <= levels_nxt;
    pha_r      <= pha_nxt;
    phb_r      <= phb_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // between ticks nothing may be left in the pending slot
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_v_r)
    else $error("pending result left over at tick boundary");

  // a stalled scan step keeps its entry and index
  a_stall_holds_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BTN && stall |=> state_r == ST_BTN && $stable(idx_r))
    else $error("button scan advanced during a stall");

  // the accumulator saturates symmetrically
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r != -8'sd128)
    else $error("encoder accumulator out of range");

  // encoder reports always carry at least one step
  a_enc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.source == SRC_ENCODER |-> out_r.step_count != 7'd0)
    else $error("empty encoder report");
`endif

endmodule
